### rtl/vau_pkg.sv
package vau_pkg;

    // Q16.16 word and pipeline depths.
    localparam int QW          = 32;
    localparam int SQRT_STAGES = 32;   // one result bit of the square root per stage
    localparam int DIV_STAGES  = 17;   // normalized components need 17 quotient bits
    localparam int SIDE_DEPTH  = SQRT_STAGES + DIV_STAGES;

    // Action codes; code 7 has no meaning and returns zeros.
    localparam logic [2:0] ACT_ADD   = 3'd0;
    localparam logic [2:0] ACT_SUB   = 3'd1;
    localparam logic [2:0] ACT_SCALE = 3'd2;
    localparam logic [2:0] ACT_DOT   = 3'd3;
    localparam logic [2:0] ACT_CROSS = 3'd4;
    localparam logic [2:0] ACT_NORM  = 3'd5;
    localparam logic [2:0] ACT_LEN   = 3'd6;

    typedef struct packed {
        logic signed [QW-1:0] val;
        logic                 ov;
    } t_sat;

    // Results computed before the square root, carried alongside it.
    typedef struct packed {
        logic [2:0]           act;
        logic signed [QW-1:0] vx;
        logic signed [QW-1:0] vy;
        logic signed [QW-1:0] vz;
        logic signed [QW-1:0] sc;
        logic                 ov;
        logic signed [QW-1:0] ax;
        logic signed [QW-1:0] ay;
        logic signed [QW-1:0] az;
    } t_side;

    // Clamp a wide signed value to the Q16.16 range.
    function automatic t_sat sat_q(input logic signed [65:0] v);
        t_sat s;
        if (v > 66'sd2147483647) begin
            s.val = 32'sh7FFF_FFFF;
            s.ov  = 1'b1;
        end else if (v < -66'sd2147483648) begin
            s.val = 32'sh8000_0000;
            s.ov  = 1'b1;
        end else begin
            s.val = v[QW-1:0];
            s.ov  = 1'b0;
        end
        return s;
    endfunction

    // Round an exact Q32.32 value to Q16.16, half toward plus infinity.
    function automatic logic signed [65:0] round_q(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd32768;
        return t >>> 16;
    endfunction

endpackage

### rtl/vec3_arithmetic_unit.sv
// Channel   Direction  Beat contents
// s_axis    in         tuser[2:0] action; tdata a_x, a_y, a_z, b_x, b_y, b_z, factor
// m_axis    out        tdata r_x, r_y, r_z, scalar_out; tuser[0] overflow
//
// One beat is accepted every cycle while the output is not held; each beat yields
// one result beat. The pipeline is made up of the lane multipliers (2), the square
// root pipeline (32, one root bit per stage; its first stage also captures the
// combinational lane merge), the component divider (17) and the output register
// (1). The whole pipeline advances together: when the output beat is held by tready
// low, every stage holds and s_axis tready drops. Reset (synchronous, active low)
// clears only the valid bits; payload registers are not reset.
module vec3_arithmetic_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [223:0] i_s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, factor
    input  logic [2:0]   i_s_axis_tuser,   // action
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // r_x, r_y, r_z, scalar_out
    output logic [0:0]   o_m_axis_tuser    // overflow
);

    localparam int QW    = vau_pkg::QW;
    localparam int DEPTH = vau_pkg::SIDE_DEPTH;

    // Global advance: the pipeline moves whenever the output slot is free or drained.
    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    logic signed [QW-1:0] w_a [3];
    logic signed [QW-1:0] w_b [3];
    logic signed [QW-1:0] w_f;
    logic [2:0]           w_act;

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign w_a[i] = i_s_axis_tdata[QW*i +: QW];
        assign w_b[i] = i_s_axis_tdata[QW*(i+3) +: QW];
    end
    assign w_f   = i_s_axis_tdata[QW*6 +: QW];
    assign w_act = i_s_axis_tuser;

    // Three lanes, one per component; the cross product takes its pairs from the
    // other two components.
    logic signed [65:0]   w_t  [3];
    logic signed [QW:0]   w_as [3];
    logic signed [QW-1:0] w_la [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vau_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_action (w_act),
            .i_a      (w_a[i]),
            .i_b      (w_b[i]),
            .i_a_j    (w_a[(i+1)%3]),
            .i_b_k    (w_b[(i+2)%3]),
            .i_a_k    (w_a[(i+2)%3]),
            .i_b_j    (w_b[(i+1)%3]),
            .i_factor (w_f),
            .o_t      (w_t[i]),
            .o_as     (w_as[i]),
            .o_a      (w_la[i])
        );
    end

    // Valid bits and the action follow the two lane stages.
    logic [1:0] r_lane_valid;
    logic [2:0] r_act1, r_act2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_valid <= '0;
        end else if (w_en) begin
            r_lane_valid <= {r_lane_valid[0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_act1 <= w_act;
            r_act2 <= r_act1;
        end
    end

    // Merge: finish every action that needs no square root, and form the sum of
    // squares for normalize and length.
    vau_pkg::t_side     n_side;
    logic [63:0]        w_sq;
    vau_pkg::t_sat      w_vs [3];
    vau_pkg::t_sat      w_dot;
    logic signed [65:0] w_dot_sum;

    assign w_sq      = w_t[0][63:0] + w_t[1][63:0] + w_t[2][63:0];
    assign w_dot_sum = w_t[0] + w_t[1] + w_t[2];
    assign w_dot     = vau_pkg::sat_q(vau_pkg::round_q(w_dot_sum));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_vs[i] = '0;
            case (r_act2)
                vau_pkg::ACT_ADD,
                vau_pkg::ACT_SUB:   w_vs[i] = vau_pkg::sat_q(66'(w_as[i]));
                vau_pkg::ACT_SCALE,
                vau_pkg::ACT_CROSS: w_vs[i] = vau_pkg::sat_q(vau_pkg::round_q(w_t[i]));
                default:            w_vs[i] = '0;
            endcase
        end
        n_side     = '0;
        n_side.act = r_act2;
        n_side.vx  = w_vs[0].val;
        n_side.vy  = w_vs[1].val;
        n_side.vz  = w_vs[2].val;
        n_side.ov  = w_vs[0].ov | w_vs[1].ov | w_vs[2].ov;
        n_side.ax  = w_la[0];
        n_side.ay  = w_la[1];
        n_side.az  = w_la[2];
        if (r_act2 == vau_pkg::ACT_DOT) begin
            n_side.sc = w_dot.val;
            n_side.ov = w_dot.ov;
        end
    end

    // Side data travels beside the root and divider stages.
    vau_pkg::t_side r_side [DEPTH];
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[DEPTH-2:0], r_lane_valid[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic [QW-1:0] w_root;

    vau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_s    (w_sq),
        .o_root (w_root)
    );

    // One divider per lane turns the components of A into a unit vector.
    localparam int SR = vau_pkg::SQRT_STAGES - 1;
    logic signed [QW-1:0]                w_na  [3];
    logic signed [vau_pkg::DIV_STAGES:0] w_q   [3];
    logic [QW-1:0]                       w_len [3];

    assign w_na[0] = r_side[SR].ax;
    assign w_na[1] = r_side[SR].ay;
    assign w_na[2] = r_side[SR].az;

    for (genvar i = 0; i < 3; i++) begin : g_div
        vau_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_na[i]),
            .i_den (w_root),
            .o_q   (w_q[i]),
            .o_den (w_len[i])
        );
    end

    // Output register.
    vau_pkg::t_side       w_last;
    logic signed [QW-1:0] n_rx, n_ry, n_rz, n_sc;
    logic                 n_ov;
    logic signed [QW-1:0] r_rx, r_ry, r_rz, r_sc;
    logic                 r_ov;
    logic [2:0]           r_out_act;
    logic                 r_out_valid;

    assign w_last = r_side[DEPTH-1];

    always_comb begin
        n_rx = w_last.vx;
        n_ry = w_last.vy;
        n_rz = w_last.vz;
        n_sc = w_last.sc;
        n_ov = w_last.ov;
        case (w_last.act)
            vau_pkg::ACT_NORM: begin
                // A zero vector has zero length and normalizes to zero.
                if (w_len[0] != '0) begin
                    n_rx = QW'(w_q[0]);
                    n_ry = QW'(w_q[1]);
                    n_rz = QW'(w_q[2]);
                end
            end
            vau_pkg::ACT_LEN: begin
                if (w_len[0][QW-1]) begin
                    n_sc = 32'sh7FFF_FFFF;
                    n_ov = 1'b1;
                end else begin
                    n_sc = w_len[0];
                end
            end
            default: begin
                n_sc = w_last.sc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_valid[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rx      <= n_rx;
            r_ry      <= n_ry;
            r_rz      <= n_rz;
            r_sc      <= n_sc;
            r_ov      <= n_ov;
            r_out_act <= w_last.act;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_sc, r_rz, r_ry, r_rx};
    assign o_m_axis_tuser  = r_ov;

    // A normalized vector never saturates.
    a_norm_no_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_act == vau_pkg::ACT_NORM) |-> !r_ov)
        else $error("normalize result flagged overflow");

    // Scalar actions leave the vector fields zero.
    a_scalar_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_act == vau_pkg::ACT_DOT || r_out_act == vau_pkg::ACT_LEN))
        |-> (r_rx == '0 && r_ry == '0 && r_rz == '0))
        else $error("scalar action produced a nonzero vector");

    // Vector actions leave the scalar field zero.
    a_vector_zero_sc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_act != vau_pkg::ACT_DOT && r_out_act != vau_pkg::ACT_LEN)
        |-> (r_sc == '0))
        else $error("vector action produced a nonzero scalar");

    // Input ready follows the output slot in the same cycle.
    a_ready_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while the output beat is held");

endmodule

### rtl/vau_lane.sv
module vau_lane (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [2:0]                     i_action,
    input  logic signed [vau_pkg::QW-1:0]  i_a,
    input  logic signed [vau_pkg::QW-1:0]  i_b,
    input  logic signed [vau_pkg::QW-1:0]  i_a_j,
    input  logic signed [vau_pkg::QW-1:0]  i_b_k,
    input  logic signed [vau_pkg::QW-1:0]  i_a_k,
    input  logic signed [vau_pkg::QW-1:0]  i_b_j,
    input  logic signed [vau_pkg::QW-1:0]  i_factor,
    output logic signed [65:0]             o_t,
    output logic signed [vau_pkg::QW:0]    o_as,
    output logic signed [vau_pkg::QW-1:0]  o_a
);

    logic signed [vau_pkg::QW-1:0] w_op_a, w_op_b;
    logic signed [63:0]            n_m1, n_m2;
    logic signed [vau_pkg::QW:0]   n_as;
    logic signed [63:0]            r_m1, r_m2;
    logic signed [vau_pkg::QW:0]   r_as1, r_as2;
    logic signed [vau_pkg::QW-1:0] r_a1, r_a2;
    logic                          r_cross;
    logic signed [65:0]            r_t;

    // One shared multiplier picks its operands by action; the second serves cross only.
    always_comb begin
        w_op_a = i_a;
        w_op_b = '0;
        case (i_action)
            vau_pkg::ACT_SCALE: w_op_b = i_factor;
            vau_pkg::ACT_DOT:   w_op_b = i_b;
            vau_pkg::ACT_CROSS: begin
                w_op_a = i_a_j;
                w_op_b = i_b_k;
            end
            vau_pkg::ACT_NORM:  w_op_b = i_a;
            vau_pkg::ACT_LEN:   w_op_b = i_a;
            default:            w_op_b = '0;
        endcase
        n_m1 = w_op_a * w_op_b;
        n_m2 = i_a_k * i_b_j;
        if (i_action == vau_pkg::ACT_SUB) begin
            n_as = 33'(i_a) - 33'(i_b);
        end else begin
            n_as = 33'(i_a) + 33'(i_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1    <= n_m1;
            r_m2    <= n_m2;
            r_as1   <= n_as;
            r_a1    <= i_a;
            r_cross <= (i_action == vau_pkg::ACT_CROSS);
            r_t     <= r_cross ? (66'(r_m1) - 66'(r_m2)) : 66'(r_m1);
            r_as2   <= r_as1;
            r_a2    <= r_a1;
        end
    end

    assign o_t  = r_t;
    assign o_as = r_as2;
    assign o_a  = r_a2;

endmodule

### rtl/vau_sqrt.sv
module vau_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [63:0]                   i_s,
    output logic [vau_pkg::QW-1:0]        o_root
);

    logic [63:0] r_rem [vau_pkg::SQRT_STAGES];
    logic [63:0] r_res [vau_pkg::SQRT_STAGES];
    logic [63:0] w_rem [vau_pkg::SQRT_STAGES];
    logic [63:0] w_res [vau_pkg::SQRT_STAGES];

    for (genvar k = 0; k < vau_pkg::SQRT_STAGES; k++) begin : g_stage
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
        logic [63:0] w_try;

        if (k == 0) begin : g_first
            assign w_rem[k] = i_s;
            assign w_res[k] = '0;
        end else begin : g_next
            assign w_rem[k] = r_rem[k-1];
            assign w_res[k] = r_res[k-1];
        end

        assign w_try = w_res[k] + Bit;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem[k] >= w_try) begin
                    r_rem[k] <= w_rem[k] - w_try;
                    r_res[k] <= (w_res[k] >> 1) + Bit;
                end else begin
                    r_rem[k] <= w_rem[k];
                    r_res[k] <= w_res[k] >> 1;
                end
            end
        end
    end

    assign o_root = r_res[vau_pkg::SQRT_STAGES-1][vau_pkg::QW-1:0];

endmodule

### rtl/vau_div.sv
module vau_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [vau_pkg::QW-1:0]  i_num,
    input  logic [vau_pkg::QW-1:0]         i_den,
    output logic signed [vau_pkg::DIV_STAGES:0] o_q,
    output logic [vau_pkg::QW-1:0]         o_den
);

    localparam int QB = vau_pkg::DIV_STAGES;
    localparam int RW = vau_pkg::QW + 16;

    logic [RW-1:0]             r_rem [QB];
    logic [QB-1:0]             r_q   [QB];
    logic                      r_neg [QB];
    logic [vau_pkg::QW-1:0]    r_den [QB];
    logic [RW-1:0]             w_rem [QB];
    logic [QB-1:0]             w_q   [QB];
    logic                      w_neg [QB];
    logic [vau_pkg::QW-1:0]    w_den [QB];
    logic [vau_pkg::QW-1:0]    w_mag;

    // The dividend is |a| scaled by 2^16; the sign is restored at the end.
    assign w_mag = i_num[vau_pkg::QW-1] ? (~i_num + 1'b1) : i_num;

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int Sh = QB - 1 - j;
        logic [RW:0] w_dsh;

        if (j == 0) begin : g_first
            assign w_rem[j] = {w_mag, 16'd0};
            assign w_q[j]   = '0;
            assign w_neg[j] = i_num[vau_pkg::QW-1];
            assign w_den[j] = i_den;
        end else begin : g_next
            assign w_rem[j] = r_rem[j-1];
            assign w_q[j]   = r_q[j-1];
            assign w_neg[j] = r_neg[j-1];
            assign w_den[j] = r_den[j-1];
        end

        assign w_dsh = (RW+1)'(w_den[j]) << Sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[j] <= w_neg[j];
                r_den[j] <= w_den[j];
                if ({1'b0, w_rem[j]} >= w_dsh) begin
                    r_rem[j]     <= w_rem[j] - w_dsh[RW-1:0];
                    r_q[j]       <= w_q[j] | (QB'(1) << Sh);
                end else begin
                    r_rem[j]     <= w_rem[j];
                    r_q[j]       <= w_q[j];
                end
            end
        end
    end

    assign o_q   = r_neg[QB-1] ? -$signed({1'b0, r_q[QB-1]}) : $signed({1'b0, r_q[QB-1]});
    assign o_den = r_den[QB-1];

endmodule

### tb/vec3_arithmetic_unit_test.sv
`timescale 1ns / 100ps

module vec3_arithmetic_unit_test;

    typedef struct {
        logic [2:0]         act;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic signed [31:0] fac;
    } t_vec_req;

    typedef struct {
        logic [31:0] r [3];
        logic [31:0] sc;
        logic        ov;
    } t_vec_res;

    int err_count = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        err_count++;
    endtask

    // Scoreboard: computes the expected result of each accepted beat and
    // compares it with the oldest one waiting when a result beat arrives.
    class vec_scoreboard;
        t_vec_res pending [$];

        // Floor division by 2^16 of the value plus one half LSB.
        static function logic signed [66:0] round_half_up(input logic signed [66:0] v);
            logic signed [66:0] t;
            t = v + 67'sd32768;
            return t >>> 16;
        endfunction

        static function logic [31:0] clamp(input logic signed [66:0] v, inout logic ov);
            if (v > 67'sd2147483647) begin
                ov = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (v < -67'sd2147483648) begin
                ov = 1'b1;
                return 32'h8000_0000;
            end
            return v[31:0];
        endfunction

        static function logic [63:0] int_sqrt(input logic [63:0] s);
            logic [63:0] res, bitv;
            res = '0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv >>= 2;
            while (bitv != 0) begin
                if (s >= res + bitv) begin
                    s = s - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function void note_input(input t_vec_req q);
            logic signed [66:0] v [3];
            logic signed [66:0] s;
            logic signed [66:0] ax [3], bx [3], f;
            logic [63:0] sumsq, len;
            t_vec_res e;
            int j, k;
            for (int i = 0; i < 3; i++) begin
                ax[i] = 67'(q.a[i]);
                bx[i] = 67'(q.b[i]);
                v[i] = '0;
            end
            f = 67'(q.fac);
            s = '0;
            e.ov = 1'b0;
            case (q.act)
                vau_pkg::ACT_ADD:
                    for (int i = 0; i < 3; i++) v[i] = ax[i] + bx[i];
                vau_pkg::ACT_SUB:
                    for (int i = 0; i < 3; i++) v[i] = ax[i] - bx[i];
                vau_pkg::ACT_SCALE:
                    for (int i = 0; i < 3; i++) v[i] = round_half_up(ax[i] * f);
                vau_pkg::ACT_DOT:
                    s = round_half_up(ax[0] * bx[0] + ax[1] * bx[1] + ax[2] * bx[2]);
                vau_pkg::ACT_CROSS: begin
                    for (int i = 0; i < 3; i++) begin
                        j = (i + 1) % 3;
                        k = (i + 2) % 3;
                        v[i] = round_half_up(ax[j] * bx[k] - ax[k] * bx[j]);
                    end
                end
                vau_pkg::ACT_NORM, vau_pkg::ACT_LEN: begin
                    // The sum of three squares always fits in 64 bits.
                    sumsq = '0;
                    for (int i = 0; i < 3; i++) sumsq += 64'(ax[i] * ax[i]);
                    len = int_sqrt(sumsq);
                    if (q.act == vau_pkg::ACT_LEN) begin
                        s = {3'b0, len};
                    end else if (len != 0) begin
                        // Signed division truncates toward zero.
                        for (int i = 0; i < 3; i++)
                            v[i] = (ax[i] * 67'sd65536) / $signed({3'b0, len});
                    end
                end
                default: ;
            endcase
            for (int i = 0; i < 3; i++) e.r[i] = clamp(v[i], e.ov);
            e.sc = clamp(s, e.ov);
            pending.push_back(e);
        endfunction

        task check_result(input logic [127:0] data, input logic ov);
            t_vec_res e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", data));
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 3; i++)
                if (data[32*i +: 32] !== e.r[i])
                    report_mismatch($sformatf("r[%0d] got %h want %h", i, data[32*i +: 32],
                                              e.r[i]));
            if (data[127:96] !== e.sc)
                report_mismatch($sformatf("scalar got %h want %h", data[127:96], e.sc));
            if (ov !== e.ov)
                report_mismatch($sformatf("overflow got %b want %b", ov, e.ov));
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [223:0] i_s_axis_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, factor
    logic [2:0]   i_s_axis_tuser;   // action
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [127:0] o_m_axis_tdata;   // r_x, r_y, r_z, scalar_out
    logic [0:0]   o_m_axis_tuser;   // overflow

    vec3_arithmetic_unit dut (.*);

    vec_scoreboard board = new();
    longint cycle_count = 0;
    bit no_idle = 0;
    t_vec_req req_q [$];

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            board.note_input(req_q.pop_front());
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
        if (cycle_count > 400000) begin
            $display("vec3_arithmetic_unit_test: errors");
            $finish;
        end
    end

    // The receiver stalls with a probability of about 38 percent except in the quiet stretch.
    always @(negedge i_clk)
        i_m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
            4: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
            default: return $urandom;
        endcase
    endfunction

    // Drives one beat and waits for it to be taken; the valid stays high into
    // the next beat when no idle cycle is drawn.
    task automatic send_beat(input t_vec_req q);
        while (!no_idle && $urandom_range(99) < 38) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        req_q.push_back(q);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= q.act;
        i_s_axis_tdata  <= {q.fac, q.b[2], q.b[1], q.b[0], q.a[2], q.a[1], q.a[0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_vec(input logic [2:0] act, input logic [31:0] w0, w1, w2, w3, w4,
                            w5, w6);
        t_vec_req q;
        q.act = act;
        q.a[0] = w0; q.a[1] = w1; q.a[2] = w2;
        q.b[0] = w3; q.b[1] = w4; q.b[2] = w5;
        q.fac = w6;
        send_beat(q);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    initial begin
        t_vec_req q;
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: every action at small values and at the extremes, the
        // zero vector normalized, and the unused action code.
        for (int act = 0; act < 8; act++) begin
            send_vec(3'(act), 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_8000,
                     32'hFFFF_8000, 32'h0000_0001, 32'h0001_8000);
            send_vec(3'(act), 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        end
        send_vec(vau_pkg::ACT_NORM, 0, 0, 0, 1, 2, 3, 4);
        send_vec(vau_pkg::ACT_LEN, 0, 0, 0, 0, 0, 0, 0);
        send_vec(vau_pkg::ACT_SCALE, 32'hFFFF_FFFF, 1, 32'h8000_0000, 0, 0, 0,
                 32'h0000_8000);
        send_vec(vau_pkg::ACT_NORM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                 0);
        send_vec(vau_pkg::ACT_NORM, 1, 0, 0, 0, 0, 0, 0);
        drain();

        // Random: all codes including the unused one, with a stretch of full rate.
        for (int n = 0; n < 450; n++) begin
            no_idle = (n >= 150 && n < 250);
            q.act = 3'($urandom_range(7));
            for (int i = 0; i < 3; i++) begin
                q.a[i] = pick_word();
                q.b[i] = pick_word();
            end
            q.fac = pick_word();
            send_beat(q);
            if (n == 300) drain();
        end
        no_idle = 0;
        drain();

        if (err_count == 0)
            $display("vec3_arithmetic_unit_test: clean");
        else
            $display("vec3_arithmetic_unit_test: errors");
        $finish;
    end
endmodule
